/* rtl/core/rv64c_operand_decoder_core_macros.svh */
// assertion helpers used by the checker of this block
`ifndef RV64C_OPERAND_DECODER_CORE_MACROS_SVH
`define RV64C_OPERAND_DECODER_CORE_MACROS_SVH

// checked only while reset is released
`define RV64OD_ASSERT(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) else $error(msg);

// checked at every edge, reset included
`define RV64OD_ASSERT_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

/* rtl/core/rv64od_pkg.sv */
package rv64od_pkg;

	localparam int KIND_W     = 5;
	localparam int REG_IDX_W  = 5;
	localparam int XLEN       = 64;
	localparam int INSN_W     = 32;
	localparam int ACC_W      = 4;
	localparam int S_TDATA_W  = 160;
	localparam int M_TDATA_W  = 216;

	localparam logic [REG_IDX_W-1:0] REG_ZERO = 5'd0;
	localparam logic [REG_IDX_W-1:0] REG_RA   = 5'd1;
	localparam logic [REG_IDX_W-1:0] REG_SP   = 5'd2;

	localparam logic [ACC_W-1:0] ACC_NONE   = 4'd0;
	localparam logic [ACC_W-1:0] ACC_WORD   = 4'd4;
	localparam logic [ACC_W-1:0] ACC_DOUBLE = 4'd8;

	typedef enum logic [KIND_W-1:0] {
		KIND_I         = 5'd0,
		KIND_R         = 5'd1,
		KIND_U         = 5'd2,
		KIND_J         = 5'd3,
		KIND_B         = 5'd4,
		KIND_LOAD      = 5'd5,
		KIND_STORE     = 5'd6,
		KIND_CSR       = 5'd7,
		KIND_CR        = 5'd8,
		KIND_CB        = 5'd9,
		KIND_C_SDSP    = 5'd10,
		KIND_C_SWSP    = 5'd11,
		KIND_C_LDSP    = 5'd12,
		KIND_C_LWSP    = 5'd13,
		KIND_C_0_IMM   = 5'd14,
		KIND_C_RS1_IMM = 5'd15,
		KIND_C_RS1P_IMM = 5'd16,
		KIND_C_0_RS2   = 5'd17,
		KIND_C_RS2_0   = 5'd18,
		KIND_C_RS1_RS2 = 5'd19,
		KIND_C_ADDI16SP = 5'd20,
		KIND_C_SW      = 5'd21,
		KIND_C_LW      = 5'd22,
		KIND_C_SD      = 5'd23,
		KIND_C_LD      = 5'd24,
		KIND_C_J       = 5'd25,
		KIND_C_JALR    = 5'd26,
		KIND_C_ADDI4SPN = 5'd27
	} kind_t;

	typedef struct packed {
		logic                 illegal;
		logic [ACC_W-1:0]     access_width;
		logic [XLEN-1:0]      mem_address;
		logic [XLEN-1:0]      target;
		logic signed [XLEN-1:0] immediate;
		logic                 dest_is_imm;
		logic [REG_IDX_W-1:0] dest_index;
		logic                 src2_is_imm;
		logic [REG_IDX_W-1:0] src2_index;
		logic                 src1_is_imm;
		logic [REG_IDX_W-1:0] src1_index;
	} dec_result_t;

endpackage

/* rtl/core/rv64od_decode.sv */
module rv64od_decode
	import rv64od_pkg::*;
(
	input  logic [KIND_W-1:0] kind,
	input  logic [INSN_W-1:0] instruction,
	input  logic [XLEN-1:0]   pc,
	input  logic [XLEN-1:0]   base_value,
	output dec_result_t       result
);

	always_comb begin
		logic [INSN_W-1:0]    w;
		logic [REG_IDX_W-1:0] rd, rs1, rs2, crr, crs2, cr1p, cr2p;
		logic [XLEN-1:0]      imm;
		logic                 is_branch;
		logic                 is_mem;

		w    = instruction;
		rd   = w[11:7];
		rs1  = w[19:15];
		rs2  = w[24:20];
		crr  = w[11:7];
		crs2 = w[6:2];
		cr1p = {2'b01, w[9:7]};
		cr2p = {2'b01, w[4:2]};

		result    = '0;
		imm       = '0;
		is_branch = 1'b0;
		is_mem    = 1'b0;

		unique case (kind_t'(kind))
			KIND_I, KIND_LOAD: begin
				result.src1_index  = rs1;
				result.src2_is_imm = 1'b1;
				imm                = {{52{w[31]}}, w[31:20]};
				result.dest_index  = rd;
				is_mem             = (kind_t'(kind) == KIND_LOAD);
			end
			KIND_R: begin
				result.src1_index = rs1;
				result.src2_index = rs2;
				result.dest_index = rd;
			end
			KIND_U: begin
				// upper immediate kept unshifted
				result.src2_is_imm = 1'b1;
				imm                = {{44{w[31]}}, w[31:12]};
				result.dest_index  = rd;
			end
			KIND_J: begin
				imm                = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
				is_branch          = 1'b1;
				result.src1_is_imm = 1'b1;
				result.dest_index  = rd;
			end
			KIND_B: begin
				imm                = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
				is_branch          = 1'b1;
				result.dest_is_imm = 1'b1;
				result.src1_index  = rs1;
				result.src2_index  = rs2;
			end
			KIND_STORE: begin
				result.src1_index  = rs1;
				result.src2_is_imm = 1'b1;
				imm                = {{52{w[31]}}, w[31:25], w[11:7]};
				result.dest_index  = rs2;
				is_mem             = 1'b1;
			end
			KIND_CSR: begin
				result.src1_index  = rs1;
				result.src2_is_imm = 1'b1;
				imm                = {52'd0, w[31:20]};
				result.dest_index  = rd;
			end
			KIND_CR: begin
				result.src1_index = cr1p;
				result.src2_index = cr2p;
				result.dest_index = cr1p;
			end
			KIND_CB: begin
				imm = {{55{w[12]}}, w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
				is_branch          = 1'b1;
				result.dest_is_imm = 1'b1;
				result.src1_index  = cr1p;
			end
			KIND_C_SDSP: begin
				result.src1_index   = REG_SP;
				result.src2_is_imm  = 1'b1;
				imm                 = {55'd0, w[9:7], w[12:10], 3'd0};
				result.dest_index   = crs2;
				is_mem              = 1'b1;
				result.access_width = ACC_DOUBLE;
			end
			KIND_C_SWSP: begin
				result.src1_index   = REG_SP;
				result.src2_is_imm  = 1'b1;
				imm                 = {56'd0, w[8:7], w[12:9], 2'd0};
				result.dest_index   = crs2;
				is_mem              = 1'b1;
				result.access_width = ACC_WORD;
			end
			KIND_C_LDSP: begin
				result.src1_index   = REG_SP;
				result.src2_is_imm  = 1'b1;
				imm                 = {55'd0, w[4:2], w[12], w[6:5], 3'd0};
				result.dest_index   = crr;
				is_mem              = 1'b1;
				result.access_width = ACC_DOUBLE;
				result.illegal      = (crr == REG_ZERO);
			end
			KIND_C_LWSP: begin
				result.src1_index   = REG_SP;
				result.src2_is_imm  = 1'b1;
				imm                 = {56'd0, w[3:2], w[12], w[6:4], 2'd0};
				result.dest_index   = crr;
				is_mem              = 1'b1;
				result.access_width = ACC_WORD;
				result.illegal      = (crr == REG_ZERO);
			end
			KIND_C_0_IMM: begin
				result.dest_index  = crr;
				result.src2_is_imm = 1'b1;
				imm                = {{58{w[12]}}, w[12], w[6:2]};
			end
			KIND_C_RS1_IMM: begin
				result.dest_index  = crr;
				result.src1_index  = crr;
				result.src2_is_imm = 1'b1;
				imm                = {{58{w[12]}}, w[12], w[6:2]};
			end
			KIND_C_RS1P_IMM: begin
				result.dest_index  = cr1p;
				result.src1_index  = cr1p;
				result.src2_is_imm = 1'b1;
				imm                = {{58{w[12]}}, w[12], w[6:2]};
			end
			KIND_C_0_RS2: begin
				result.src2_index = crs2;
				result.dest_index = crr;
			end
			KIND_C_RS2_0: begin
				result.src1_index = crr;
				result.src2_index = crs2;
			end
			KIND_C_RS1_RS2: begin
				result.src1_index = crr;
				result.src2_index = crs2;
				result.dest_index = crr;
			end
			KIND_C_ADDI16SP: begin
				imm                = {{54{w[12]}}, w[12], w[4:3], w[5], w[2], w[6], 4'd0};
				result.src1_index  = REG_SP;
				result.src2_is_imm = 1'b1;
				result.dest_index  = REG_SP;
				result.illegal     = ({w[12], w[6:2]} == 6'd0);
			end
			KIND_C_SW, KIND_C_LW: begin
				result.src1_index   = cr1p;
				result.src2_is_imm  = 1'b1;
				imm                 = {57'd0, w[5], w[12:10], w[6], 2'd0};
				result.dest_index   = cr2p;
				is_mem              = 1'b1;
				result.access_width = ACC_WORD;
			end
			KIND_C_SD, KIND_C_LD: begin
				result.src1_index   = cr1p;
				result.src2_is_imm  = 1'b1;
				imm                 = {56'd0, w[6:5], w[12:10], 3'd0};
				result.dest_index   = cr2p;
				is_mem              = 1'b1;
				result.access_width = ACC_DOUBLE;
			end
			KIND_C_J: begin
				imm = {{52{w[12]}}, w[12], w[8], w[10:9], w[6], w[7], w[2], w[11],
					w[5:3], 1'b0};
				is_branch          = 1'b1;
				result.src1_is_imm = 1'b1;
			end
			KIND_C_JALR: begin
				result.src1_index = crr;
				result.dest_index = REG_RA;
			end
			KIND_C_ADDI4SPN: begin
				imm                = {54'd0, w[10:7], w[12:11], w[5], w[6], 2'd0};
				result.src1_index  = REG_SP;
				result.src2_is_imm = 1'b1;
				result.dest_index  = cr2p;
				result.illegal     = (w[12:5] == 8'd0);
			end
			default: begin
				// unassigned format codes
				result.illegal = 1'b1;
			end
		endcase

		result.immediate   = imm;
		result.target      = is_branch ? pc + imm : '0;
		result.mem_address = is_mem ? base_value + imm : '0;
	end

endmodule

/* rtl/core/rv64c_operand_decoder_core.sv */
// rv64 operand decoder, base and compressed formats
// input stream s_axis: one instruction word per transfer; tuser carries the
// format code picked by the opcode table, tdata the instruction, its pc and
// the rs1 value used for address forming
// output stream m_axis: one decoded word per input word, same order
// (register numbers, immediate flags, immediate, branch target, effective
// address, access width and a reserved-encoding flag)
// data path: a word accepted into the input register passes through the
// decode logic and its two 64-bit adders into the result register, from
// which it is offered on m_axis
// throughput: one word per cycle while m_axis_tready is high; the two
// registers advance separately, so the block still takes one more word
// while a finished word waits if the input register is empty
// when m_axis_tready is low the result register holds and s_axis_tready drops
// once both registers are full
// reset clears both valid flags; no stored state lies between words
module rv64c_operand_decoder_core
	import rv64od_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // instruction, pc, base_value
	input  logic [KIND_W-1:0]    s_axis_tuser,  // kind

	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// src1_index, src1_is_imm, src2_index, src2_is_imm, dest_index,
	// dest_is_imm, immediate, target, mem_address, access_width, illegal, pad
	output logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic                valid_s1;
	logic [KIND_W-1:0]   kind_s1;
	logic [INSN_W-1:0]   insn_s1;
	logic [XLEN-1:0]     pc_s1;
	logic [XLEN-1:0]     base_s1;
	logic                valid_s2;
	dec_result_t         res_s2;
	dec_result_t         dec;
	logic                adv_s1;
	logic                adv_s2;

	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1)
				valid_s1 <= s_axis_tvalid;
			if (adv_s2)
				valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && s_axis_tvalid) begin
			kind_s1 <= s_axis_tuser;
			insn_s1 <= s_axis_tdata[INSN_W-1:0];
			pc_s1   <= s_axis_tdata[INSN_W+XLEN-1:INSN_W];
			base_s1 <= s_axis_tdata[INSN_W+2*XLEN-1:INSN_W+XLEN];
		end
		if (adv_s2 && valid_s1)
			res_s2 <= dec;
	end

	rv64od_decode u_decode (
		.kind        (kind_s1),
		.instruction (insn_s1),
		.pc          (pc_s1),
		.base_value  (base_s1),
		.result      (dec)
	);

	assign m_axis_tvalid = valid_s2;
	// struct packs src1_index lowest; top bit is byte padding
	assign m_axis_tdata  = {1'b0, res_s2};

endmodule

/* rtl/core/rv64od_checker.sv */
`include "rv64c_operand_decoder_core_macros.svh"

module rv64od_checker
	import rv64od_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tready,
	input  logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	input  logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic [ACC_W-1:0] acc_w;
	logic [XLEN-1:0]  tgt;
	logic             src1_imm;
	logic             dest_imm;

	assign acc_w    = m_axis_tdata[213:210];
	assign tgt      = m_axis_tdata[145:82];
	assign src1_imm = m_axis_tdata[5];
	assign dest_imm = m_axis_tdata[17];

	// a stalled word stays put
	`RV64OD_ASSERT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output word changed while stalled")
	// nothing offered while reset is applied
	`RV64OD_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !m_axis_tvalid, "output valid during reset")
	// empty result register means the input side is open
	`RV64OD_ASSERT(a_ready_free, clk, arst_n, !m_axis_tvalid |-> s_axis_tready, "input blocked with empty pipeline")
	`RV64OD_ASSERT(a_acc_width, clk, arst_n, m_axis_tvalid |-> (acc_w == ACC_NONE) || (acc_w == ACC_WORD) || (acc_w == ACC_DOUBLE), "bad access width")
	// only branch and jump formats produce a target
	`RV64OD_ASSERT(a_tgt_branch, clk, arst_n, m_axis_tvalid && (tgt != '0) |-> src1_imm || dest_imm, "target without branch flag")

endmodule

bind rv64c_operand_decoder_core rv64od_checker u_checker (.*);

/* tb/tb_rv64c_operand_decoder_core.sv */
module tb_rv64c_operand_decoder_core;
	import rv64od_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;  // instruction, pc, base_value
	logic [KIND_W-1:0]    s_axis_tuser;  // kind
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	// src1_index, src1_is_imm, src2_index, src2_is_imm, dest_index,
	// dest_is_imm, immediate, target, mem_address, access_width, illegal, pad
	logic [M_TDATA_W-1:0] m_axis_tdata;

	bit no_idle;

	class decode_scoreboard;
		dec_result_t decoded_words_due[$];
		int          mismatches;

		function dec_result_t decode_operands(logic [KIND_W-1:0] k, logic [31:0] w,
			logic [XLEN-1:0] pc, logic [XLEN-1:0] base);
			dec_result_t     r;
			logic [REG_IDX_W-1:0] rd, rs1, rs2, crd, crs2, cr1p, cr2p;
			logic [XLEN-1:0] imm;
			logic [20:0]     off_j;
			logic [12:0]     off_b;
			logic [11:0]     off_cj;
			logic [9:0]      off_sp16;
			logic [8:0]      off_cb;
			logic            is_mem;
			r = '0;
			imm = '0;
			is_mem = 1'b0;
			rd = w[11:7];
			rs1 = w[19:15];
			rs2 = w[24:20];
			crd = w[11:7];
			crs2 = w[6:2];
			cr1p = {2'b01, w[9:7]};
			cr2p = {2'b01, w[4:2]};
			case (kind_t'(k))
				KIND_I, KIND_LOAD: begin
					r.src1_index = rs1;
					r.src2_is_imm = 1'b1;
					imm = 64'($signed(w[31:20]));
					r.dest_index = rd;
					is_mem = (kind_t'(k) == KIND_LOAD);
				end
				KIND_R: begin
					r.src1_index = rs1;
					r.src2_index = rs2;
					r.dest_index = rd;
				end
				KIND_U: begin
					// upper immediate stays unshifted
					r.src2_is_imm = 1'b1;
					imm = 64'($signed(w[31:12]));
					r.dest_index = rd;
				end
				KIND_J: begin
					off_j = {w[31], w[19:12], w[20], w[30:21], 1'b0};
					imm = 64'($signed(off_j));
					r.target = pc + imm;
					r.src1_is_imm = 1'b1;
					r.dest_index = rd;
				end
				KIND_B: begin
					off_b = {w[31], w[7], w[30:25], w[11:8], 1'b0};
					imm = 64'($signed(off_b));
					r.target = pc + imm;
					r.dest_is_imm = 1'b1;
					r.src1_index = rs1;
					r.src2_index = rs2;
				end
				KIND_STORE: begin
					r.src1_index = rs1;
					r.src2_is_imm = 1'b1;
					imm = 64'($signed({w[31:25], w[11:7]}));
					r.dest_index = rs2;
					is_mem = 1'b1;
				end
				KIND_CSR: begin
					r.src1_index = rs1;
					r.src2_is_imm = 1'b1;
					imm = {52'd0, w[31:20]};
					r.dest_index = rd;
				end
				KIND_CR: begin
					r.src1_index = cr1p;
					r.src2_index = cr2p;
					r.dest_index = cr1p;
				end
				KIND_CB: begin
					off_cb = {w[12], w[6:5], w[2], w[11:10], w[4:3], 1'b0};
					imm = 64'($signed(off_cb));
					r.target = pc + imm;
					r.dest_is_imm = 1'b1;
					r.src1_index = cr1p;
				end
				KIND_C_SDSP, KIND_C_SWSP, KIND_C_LDSP, KIND_C_LWSP: begin
					r.src1_index = REG_SP;
					r.src2_is_imm = 1'b1;
					is_mem = 1'b1;
					case (kind_t'(k))
						KIND_C_SDSP: begin
							imm = {55'd0, w[9:7], w[12:10], 3'b000};
							r.dest_index = crs2;
							r.access_width = ACC_DOUBLE;
						end
						KIND_C_SWSP: begin
							imm = {56'd0, w[8:7], w[12:9], 2'b00};
							r.dest_index = crs2;
							r.access_width = ACC_WORD;
						end
						KIND_C_LDSP: begin
							imm = {55'd0, w[4:2], w[12], w[6:5], 3'b000};
							r.dest_index = crd;
							r.access_width = ACC_DOUBLE;
							r.illegal = (crd == REG_ZERO);
						end
						default: begin
							imm = {56'd0, w[3:2], w[12], w[6:4], 2'b00};
							r.dest_index = crd;
							r.access_width = ACC_WORD;
							r.illegal = (crd == REG_ZERO);
						end
					endcase
				end
				KIND_C_0_IMM, KIND_C_RS1_IMM, KIND_C_RS1P_IMM: begin
					r.dest_index = (kind_t'(k) == KIND_C_RS1P_IMM) ? cr1p : crd;
					r.src1_index = (kind_t'(k) == KIND_C_0_IMM) ? REG_ZERO : r.dest_index;
					r.src2_is_imm = 1'b1;
					imm = 64'($signed({w[12], w[6:2]}));
				end
				KIND_C_0_RS2: begin
					r.src2_index = crs2;
					r.dest_index = crd;
				end
				KIND_C_RS2_0: begin
					r.src1_index = crd;
					r.src2_index = crs2;
				end
				KIND_C_RS1_RS2: begin
					r.src1_index = crd;
					r.src2_index = crs2;
					r.dest_index = crd;
				end
				KIND_C_ADDI16SP: begin
					off_sp16 = {w[12], w[4:3], w[5], w[2], w[6], 4'b0000};
					imm = 64'($signed(off_sp16));
					r.src1_index = REG_SP;
					r.src2_is_imm = 1'b1;
					r.dest_index = REG_SP;
					r.illegal = (imm == '0);
				end
				KIND_C_SW, KIND_C_LW: begin
					r.src1_index = cr1p;
					r.src2_is_imm = 1'b1;
					imm = {57'd0, w[5], w[12:10], w[6], 2'b00};
					r.dest_index = cr2p;
					r.access_width = ACC_WORD;
					is_mem = 1'b1;
				end
				KIND_C_SD, KIND_C_LD: begin
					r.src1_index = cr1p;
					r.src2_is_imm = 1'b1;
					imm = {56'd0, w[6:5], w[12:10], 3'b000};
					r.dest_index = cr2p;
					r.access_width = ACC_DOUBLE;
					is_mem = 1'b1;
				end
				KIND_C_J: begin
					off_cj = {w[12], w[8], w[10:9], w[6], w[7], w[2], w[11], w[5:3], 1'b0};
					imm = 64'($signed(off_cj));
					r.target = pc + imm;
					r.src1_is_imm = 1'b1;
				end
				KIND_C_JALR: begin
					r.src1_index = crd;
					r.dest_index = REG_RA;
				end
				KIND_C_ADDI4SPN: begin
					imm = {54'd0, w[10:7], w[12:11], w[5], w[6], 2'b00};
					r.src1_index = REG_SP;
					r.src2_is_imm = 1'b1;
					r.dest_index = cr2p;
					r.illegal = (imm == '0);
				end
				default: begin
					// codes past the table decode to nothing but the illegal flag
					r.illegal = 1'b1;
				end
			endcase
			r.immediate = imm;
			r.mem_address = is_mem ? base + imm : '0;
			return r;
		endfunction

		function void note_instruction(logic [KIND_W-1:0] k, logic [S_TDATA_W-1:0] data);
			decoded_words_due.push_back(decode_operands(k, data[31:0], data[95:32],
				data[159:96]));
		endfunction

		function void report_field(string name, logic [XLEN-1:0] e, logic [XLEN-1:0] a);
			if (e !== a) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch %s: expected %h got %h", name, e, a);
			end
		endfunction

		function void check_decoded(logic [M_TDATA_W-1:0] data);
			dec_result_t got, e;
			got = dec_result_t'(data[214:0]);
			if (decoded_words_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: unexpected word %h", data);
				return;
			end
			e = decoded_words_due.pop_front();
			report_field("src1_index", XLEN'(e.src1_index), XLEN'(got.src1_index));
			report_field("src1_is_imm", XLEN'(e.src1_is_imm), XLEN'(got.src1_is_imm));
			report_field("src2_index", XLEN'(e.src2_index), XLEN'(got.src2_index));
			report_field("src2_is_imm", XLEN'(e.src2_is_imm), XLEN'(got.src2_is_imm));
			report_field("dest_index", XLEN'(e.dest_index), XLEN'(got.dest_index));
			report_field("dest_is_imm", XLEN'(e.dest_is_imm), XLEN'(got.dest_is_imm));
			report_field("immediate", e.immediate, got.immediate);
			report_field("target", e.target, got.target);
			report_field("mem_address", e.mem_address, got.mem_address);
			report_field("access_width", XLEN'(e.access_width), XLEN'(got.access_width));
			report_field("illegal", XLEN'(e.illegal), XLEN'(got.illegal));
		endfunction
	endclass

	decode_scoreboard sb = new();

	rv64c_operand_decoder_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// mostly short gaps, now and then a long one
	function automatic int idle_len();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [XLEN-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return {32'd0, $urandom};
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_word(input logic [KIND_W-1:0] k, input logic [31:0] w,
		input logic [XLEN-1:0] pc, input logic [XLEN-1:0] base);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= k;
		s_axis_tdata <= {base, pc, w};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic send_random_word();
		logic [KIND_W-1:0] k;
		logic [31:0]       w;
		if ($urandom_range(0, 15) == 0)
			k = KIND_W'($urandom_range(28, 31));
		else
			k = KIND_W'($urandom_range(0, 27));
		w = $urandom;
		case ($urandom_range(0, 7))
			0: w[12:2] = '0;  // zero compressed immediates
			1: w[11:7] = '0;  // zero rd
			2: w = '1;
			default: ;
		endcase
		send_word(k, w, pick_value(), pick_value());
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.decoded_words_due.size() != 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_instruction(s_axis_tuser, s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_decoded(m_axis_tdata);
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			int stall;
			stall = idle_len();
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("tb_rv64c_operand_decoder_core failed");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every format, alternately with an all-zero and an all-one word, pc and base at the extremes
		for (int k = 0; k < 28; k++)
			send_word(KIND_W'(k), k[0] ? '1 : '0, (k % 3 == 0) ? '1 : '0,
				(k % 3 == 1) ? '1 : 64'h8000_0000_0000_0000);
		// zero rd in C.LWSP, a zero immediate in C.ADDI4SPN and a nonzero one in C.ADDI16SP
		send_word(KIND_C_LWSP, 32'h0000_1000, 64'h10, '1);
		send_word(KIND_C_ADDI4SPN, '0, '0, 64'h40);
		send_word(KIND_C_ADDI16SP, 32'hffff_e07f, '1, '0);
		// codes past the table
		send_word(KIND_W'(28), '0, '0, '0);
		send_word(KIND_W'(31), '1, '1, '1);

		// let everything already sent come out before carrying on
		drain_results();

		for (int i = 0; i < 650; i++) begin
			if (i == 300)
				drain_results();
			no_idle = (i >= 450 && i < 520);
			send_random_word();
		end
		s_axis_tvalid <= 1'b0;
		no_idle = 1'b0;

		drain_results();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.decoded_words_due.size() == 0)
			$display("tb_rv64c_operand_decoder_core passed");
		else
			$display("tb_rv64c_operand_decoder_core failed");
		$finish;
	end

endmodule
